// ===== rtl/csvft_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the CSV field tokenizer.
// Depends on nothing; the front end, queue, back end, top level and testbench use it.

package csvft_pkg;

    // Characters that steer the lexer.
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Lexer state codes.
    localparam logic [2:0] S_START    = 3'd0;
    localparam logic [2:0] S_ROWSTART = 3'd1;
    localparam logic [2:0] S_FIELD    = 3'd2;
    localparam logic [2:0] S_QUOTED   = 3'd3;
    localparam logic [2:0] S_QSEEN    = 3'd4;
    localparam logic [2:0] S_AFTERQ   = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    // Input item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOI  = 1'b1;

    // Result kinds.
    localparam logic [2:0] RK_VALUE     = 3'd0;
    localparam logic [2:0] RK_FIELD_END = 3'd1;
    localparam logic [2:0] RK_NEWLINE   = 3'd2;
    localparam logic [2:0] RK_END       = 3'd3;
    localparam logic [2:0] RK_ERROR     = 3'd4;

    // Error codes.
    localparam logic [1:0] ERR_STRAY_QUOTE  = 2'd0;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd1;
    localparam logic [1:0] ERR_AFTER_QUOTE  = 2'd2;

    // Command queue depth, pointer width and fill count width.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One result without its value byte.
    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] err;
    } res_t;

    // All results caused by one input item; slot 0 goes out first.
    typedef struct packed {
        logic [1:0]     count;
        res_t [2:0]     slot;
        logic [7:0]     value;
    } cmd_t;

    // Write side of the command queue.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_wr_t;

    // Read side of the command queue.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_rd_t;

    function automatic res_t mk_res(input logic [2:0] kind, input logic [1:0] err);
        res_t r;
        r.kind = kind;
        r.err  = err;
        return r;
    endfunction

endpackage

// ===== rtl/csvft_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input bytes and the result tokens.
// Depends on nothing.

interface csvft_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface csvft_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] result_kind;
    logic [7:0] value_byte;
    logic [1:0] error_code;
    logic       last;

    modport source (output valid, output result_kind, output value_byte,
                    output error_code, output last, input ready);
    modport sink   (input valid, input result_kind, input value_byte,
                    input error_code, input last, output ready);
endinterface

// ===== rtl/csvft_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input items, runs the lexer state machine and writes one
// command per item that causes results. Depends on csvft_pkg and csvft_if.

module csvft_front (
    input  logic                 clk,
    input  logic                 rst_n,
    csvft_in_if.sink             in_ch,
    input  logic                 q_full,
    output csvft_pkg::q_wr_t     q_wr,
    output logic                 done
);

    logic [2:0]      state_reg;
    logic [2:0]      state_next;
    logic [2:0]      calc_state;
    csvft_pkg::cmd_t cmd;
    logic            fire;
    logic [7:0]      c;
    logic            is_comma;
    logic            is_nl;
    logic            is_quote;

    assign in_ch.ready = !q_full;
    assign fire        = in_ch.valid && in_ch.ready;
    assign c           = in_ch.data_byte;
    assign is_comma    = (c == csvft_pkg::CH_COMMA);
    assign is_nl       = (c == csvft_pkg::CH_NL);
    assign is_quote    = (c == csvft_pkg::CH_QUOTE);

    // Decode one item into its results and the following lexer state.
    always_comb
    begin
        cmd        = '0;
        calc_state = state_reg;
        if (state_reg == csvft_pkg::S_DONE || state_reg > csvft_pkg::S_DONE)
        begin
            // Input after end of input is dropped.
            calc_state = state_reg;
        end
        else if (in_ch.kind == csvft_pkg::KIND_EOI)
        begin
            calc_state = csvft_pkg::S_DONE;
            if (state_reg == csvft_pkg::S_QUOTED)
            begin
                cmd.count   = 2'd3;
                cmd.slot[0] = csvft_pkg::mk_res(csvft_pkg::RK_ERROR,
                                                csvft_pkg::ERR_UNTERMINATED);
                cmd.slot[1] = csvft_pkg::mk_res(csvft_pkg::RK_FIELD_END, 2'd0);
                cmd.slot[2] = csvft_pkg::mk_res(csvft_pkg::RK_END, 2'd0);
            end
            else if (state_reg == csvft_pkg::S_ROWSTART)
            begin
                cmd.count   = 2'd1;
                cmd.slot[0] = csvft_pkg::mk_res(csvft_pkg::RK_END, 2'd0);
            end
            else
            begin
                cmd.count   = 2'd2;
                cmd.slot[0] = csvft_pkg::mk_res(csvft_pkg::RK_FIELD_END, 2'd0);
                cmd.slot[1] = csvft_pkg::mk_res(csvft_pkg::RK_END, 2'd0);
            end
        end
        else if (is_comma && state_reg != csvft_pkg::S_QUOTED)
        begin
            // A comma ends the field everywhere but inside quotes.
            cmd.count   = 2'd1;
            cmd.slot[0] = csvft_pkg::mk_res(csvft_pkg::RK_FIELD_END, 2'd0);
            calc_state  = csvft_pkg::S_START;
        end
        else if (is_nl && state_reg != csvft_pkg::S_QUOTED)
        begin
            // A newline ends the field and gives a newline token.
            cmd.count   = 2'd2;
            cmd.slot[0] = csvft_pkg::mk_res(csvft_pkg::RK_FIELD_END, 2'd0);
            cmd.slot[1] = csvft_pkg::mk_res(csvft_pkg::RK_NEWLINE, 2'd0);
            calc_state  = csvft_pkg::S_ROWSTART;
        end
        else
        begin
            case (state_reg)
                csvft_pkg::S_START, csvft_pkg::S_ROWSTART:
                begin
                    if (is_quote)
                    begin
                        calc_state = csvft_pkg::S_QUOTED;
                    end
                    else
                    begin
                        cmd.count   = 2'd1;
                        cmd.slot[0] = csvft_pkg::mk_res(csvft_pkg::RK_VALUE, 2'd0);
                        cmd.value   = c;
                        calc_state  = csvft_pkg::S_FIELD;
                    end
                end
                csvft_pkg::S_FIELD:
                begin
                    cmd.count = 2'd1;
                    if (is_quote)
                    begin
                        cmd.slot[0] = csvft_pkg::mk_res(csvft_pkg::RK_ERROR,
                                                        csvft_pkg::ERR_STRAY_QUOTE);
                    end
                    else
                    begin
                        cmd.slot[0] = csvft_pkg::mk_res(csvft_pkg::RK_VALUE, 2'd0);
                        cmd.value   = c;
                    end
                end
                csvft_pkg::S_QUOTED:
                begin
                    if (is_quote)
                    begin
                        calc_state = csvft_pkg::S_QSEEN;
                    end
                    else
                    begin
                        cmd.count   = 2'd1;
                        cmd.slot[0] = csvft_pkg::mk_res(csvft_pkg::RK_VALUE, 2'd0);
                        cmd.value   = c;
                    end
                end
                csvft_pkg::S_QSEEN:
                begin
                    cmd.count = 2'd1;
                    if (is_quote)
                    begin
                        // A doubled quote stands for one quote byte.
                        cmd.slot[0] = csvft_pkg::mk_res(csvft_pkg::RK_VALUE, 2'd0);
                        cmd.value   = csvft_pkg::CH_QUOTE;
                        calc_state  = csvft_pkg::S_QUOTED;
                    end
                    else
                    begin
                        cmd.slot[0] = csvft_pkg::mk_res(csvft_pkg::RK_ERROR,
                                                        csvft_pkg::ERR_AFTER_QUOTE);
                        calc_state  = csvft_pkg::S_AFTERQ;
                    end
                end
                default:
                begin
                    // After the closing quote every other byte is an error.
                    cmd.count   = 2'd1;
                    cmd.slot[0] = csvft_pkg::mk_res(csvft_pkg::RK_ERROR,
                                                    csvft_pkg::ERR_AFTER_QUOTE);
                end
            endcase
        end
    end

    assign state_next = fire ? calc_state : state_reg;
    assign q_wr.valid = fire && (cmd.count != 2'd0);
    assign q_wr.cmd   = cmd;
    assign done       = (state_reg == csvft_pkg::S_DONE);

    // Lexer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csvft_pkg::S_START;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/csvft_queue.sv =====
`timescale 1ns / 1ps
// Small command queue between the front end and the result sequencer.
// Depends on csvft_pkg.

module csvft_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  csvft_pkg::q_wr_t  q_wr,
    input  logic              pop,
    output csvft_pkg::q_rd_t  q_rd,
    output logic              full
);

    csvft_pkg::cmd_t                 entry_reg [csvft_pkg::QUEUE_DEPTH];
    logic [csvft_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [csvft_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [csvft_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [csvft_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [csvft_pkg::QCNT_W-1:0]    cnt_reg;
    logic [csvft_pkg::QCNT_W-1:0]    cnt_next;
    logic                            push;
    logic                            do_pop;

    assign full   = (cnt_reg == csvft_pkg::QCNT_W'(csvft_pkg::QUEUE_DEPTH));
    assign push   = q_wr.valid && !full;
    assign do_pop = pop && (cnt_reg != '0);

    assign q_rd.valid = (cnt_reg != '0);
    assign q_rd.cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage; payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= q_wr.cmd;
        end
    end

endmodule

// ===== rtl/csvft_back.sv =====
`timescale 1ns / 1ps
// Back end: walks the results of the command at the head of the queue and
// drives them into the output register, one per transfer.
// Depends on csvft_pkg and csvft_if.

module csvft_back (
    input  logic              clk,
    input  logic              rst_n,
    input  csvft_pkg::q_rd_t  q_rd,
    output logic              pop,
    csvft_out_if.source       out_ch
);

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [2:0]      kind_reg;
    logic [7:0]      value_reg;
    logic [1:0]      err_reg;
    logic            last_reg;
    logic [1:0]      sel_reg;
    logic [1:0]      sel_next;
    logic            load;
    logic            sel_last;
    csvft_pkg::res_t cur;

    assign load     = q_rd.valid && (!out_valid_reg || out_ch.ready);
    assign cur      = q_rd.cmd.slot[sel_reg];
    assign sel_last = (sel_reg == q_rd.cmd.count - 2'd1);
    assign pop      = load && sel_last;

    // Slot counter and output valid.
    always_comb
    begin
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            sel_next       = sel_last ? 2'd0 : sel_reg + 2'd1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= cur.kind;
            err_reg   <= cur.err;
            value_reg <= (cur.kind == csvft_pkg::RK_VALUE) ? q_rd.cmd.value : 8'd0;
            last_reg  <= sel_last;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_kind = kind_reg;
    assign out_ch.value_byte  = value_reg;
    assign out_ch.error_code  = err_reg;
    assign out_ch.last        = last_reg;

endmodule

// ===== rtl/csv_field_tokenizer.sv =====
`timescale 1ns / 1ps
// CSV field tokenizer top level. A result is registered in the command queue, then
// in the output register, after its input transfer. Throughput: one input byte per
// cycle while each causes at most one result and the output is ready; the back end
// sends one result per cycle while ready; a four-entry queue absorbs multi-result items.
// Reset (asynchronous, active low) puts the lexer at field start and empties all.

module csv_field_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    csvft_in_if.sink    in_ch,
    csvft_out_if.source out_ch
);

    csvft_pkg::q_wr_t q_wr;
    csvft_pkg::q_rd_t q_rd;
    logic             q_full;
    logic             pop;
    logic             done;

    csvft_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_wr   (q_wr),
        .done   (done)
    );

    csvft_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (pop),
        .q_rd  (q_rd),
        .full  (q_full)
    );

    csvft_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_rd   (q_rd),
        .pop    (pop),
        .out_ch (out_ch)
    );

    // A command is never written into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_wr.valid |-> !q_full)
        else $error("command written into a full queue");

    // Once end of input has been seen no further command is issued.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !q_wr.valid)
        else $error("command issued after end of input");

    // Only value results carry a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.result_kind != csvft_pkg::RK_VALUE)
            |-> (out_ch.value_byte == 8'd0))
        else $error("non-value result carries a byte");

    // The sequencer only pops a queue entry that exists.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_rd.valid)
        else $error("pop from an empty queue");

endmodule

// ===== dv/csv_field_tokenizer_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the CSV field tokenizer: directed table, then random records.
// Depends on csvft_pkg, the csvft_in_if/csvft_out_if channels and csv_field_tokenizer.

module csv_field_tokenizer_test;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 350;
    localparam int CYCLE_LIMIT   = 200000;

    // One expected token as it appears on the result channel.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [1:0] err;
        logic       last;
    } token_t;

    // One input transfer; typed rows carry their expected tokens.
    typedef struct packed {
        logic         kind;
        logic [7:0]   ch;
        logic         typed;
        logic [1:0]   n_exp;
        token_t [2:0] exp;
    } stim_row_t;

    localparam token_t NO_TOK = '0;

    logic clk;
    logic rst_n;

    csvft_in_if  in_ch ();
    csvft_out_if out_ch ();

    csv_field_tokenizer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    stim_row_t directed_rows [DIRECTED_ROWS];
    stim_row_t stimulus [$];
    token_t    pending_tokens [$];
    token_t    predicted [3];
    logic [2:0] lex_state;
    int        accepted_count;
    int        mismatches;
    int        cycle_count;

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------

    function automatic token_t tok(input logic [2:0] kind, input logic [7:0] value,
                                   input logic [1:0] err, input logic last);
        token_t t;
        t.kind  = kind;
        t.value = value;
        t.err   = err;
        t.last  = last;
        return t;
    endfunction

    function automatic void emit(inout int n, input logic [2:0] kind,
                                 input logic [7:0] value, input logic [1:0] err);
        predicted[n] = tok(kind, value, err, 1'b0);
        n++;
    endfunction

    // A comma or newline closes the field; a newline also opens a new row.
    function automatic bit close_field(inout int n, input logic [7:0] ch);
        if (ch == csvft_pkg::CH_COMMA)
        begin
            emit(n, csvft_pkg::RK_FIELD_END, 8'h00, 2'd0);
            lex_state = csvft_pkg::S_START;
            return 1'b1;
        end
        if (ch == csvft_pkg::CH_NL)
        begin
            emit(n, csvft_pkg::RK_FIELD_END, 8'h00, 2'd0);
            emit(n, csvft_pkg::RK_NEWLINE, 8'h00, 2'd0);
            lex_state = csvft_pkg::S_ROWSTART;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the lexer by one input item and fills predicted[]; returns the count.
    function automatic int tokenize_byte(input logic kind, input logic [7:0] ch);
        int n;
        n = 0;
        if (lex_state > csvft_pkg::S_AFTERQ)
            return 0;
        if (kind == csvft_pkg::KIND_EOI)
        begin
            if (lex_state == csvft_pkg::S_QUOTED)
                emit(n, csvft_pkg::RK_ERROR, 8'h00, csvft_pkg::ERR_UNTERMINATED);
            if (lex_state != csvft_pkg::S_ROWSTART)
                emit(n, csvft_pkg::RK_FIELD_END, 8'h00, 2'd0);
            emit(n, csvft_pkg::RK_END, 8'h00, 2'd0);
            lex_state = csvft_pkg::S_DONE;
        end
        else
        begin
            case (lex_state)
                csvft_pkg::S_START, csvft_pkg::S_ROWSTART:
                begin
                    if (!close_field(n, ch))
                    begin
                        if (ch == csvft_pkg::CH_QUOTE)
                            lex_state = csvft_pkg::S_QUOTED;
                        else
                        begin
                            emit(n, csvft_pkg::RK_VALUE, ch, 2'd0);
                            lex_state = csvft_pkg::S_FIELD;
                        end
                    end
                end
                csvft_pkg::S_FIELD:
                begin
                    if (!close_field(n, ch))
                    begin
                        if (ch == csvft_pkg::CH_QUOTE)
                            emit(n, csvft_pkg::RK_ERROR, 8'h00, csvft_pkg::ERR_STRAY_QUOTE);
                        else
                            emit(n, csvft_pkg::RK_VALUE, ch, 2'd0);
                    end
                end
                csvft_pkg::S_QUOTED:
                begin
                    if (ch == csvft_pkg::CH_QUOTE)
                        lex_state = csvft_pkg::S_QSEEN;
                    else
                        emit(n, csvft_pkg::RK_VALUE, ch, 2'd0);
                end
                csvft_pkg::S_QSEEN:
                begin
                    if (ch == csvft_pkg::CH_QUOTE)
                    begin
                        emit(n, csvft_pkg::RK_VALUE, csvft_pkg::CH_QUOTE, 2'd0);
                        lex_state = csvft_pkg::S_QUOTED;
                    end
                    else if (!close_field(n, ch))
                    begin
                        emit(n, csvft_pkg::RK_ERROR, 8'h00, csvft_pkg::ERR_AFTER_QUOTE);
                        lex_state = csvft_pkg::S_AFTERQ;
                    end
                end
                default:
                begin
                    if (!close_field(n, ch))
                        emit(n, csvft_pkg::RK_ERROR, 8'h00, csvft_pkg::ERR_AFTER_QUOTE);
                end
            endcase
        end
        if (n > 0)
            predicted[n - 1].last = 1'b1;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    function automatic stim_row_t row_typed(input logic kind, input logic [7:0] ch,
                                            input logic [1:0] n, input token_t t0,
                                            input token_t t1, input token_t t2);
        stim_row_t r;
        r.kind   = kind;
        r.ch     = ch;
        r.typed  = 1'b1;
        r.n_exp  = n;
        r.exp[0] = t0;
        r.exp[1] = t1;
        r.exp[2] = t2;
        return r;
    endfunction

    function automatic stim_row_t row_pred(input logic kind, input logic [7:0] ch);
        stim_row_t r;
        r       = '0;
        r.kind  = kind;
        r.ch    = ch;
        return r;
    endfunction

    function automatic void push_byte(input logic [7:0] ch);
        stimulus.push_back(row_pred(csvft_pkg::KIND_BYTE, ch));
    endfunction

    // A random byte that neither ends a field nor opens a quote.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == csvft_pkg::CH_COMMA || b == csvft_pkg::CH_NL || b == csvft_pkg::CH_QUOTE)
            b = 8'h41 + 8'($urandom_range(0, 25));
        return b;
    endfunction

    // Appends one field: mostly well formed, sometimes malformed or pure noise.
    function automatic void gen_field();
        int len;
        logic [7:0] b;
        len = $urandom_range(0, 6);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                push_byte(plain_byte());
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 11) == 0)
                        push_byte(csvft_pkg::CH_QUOTE);
                    else
                        push_byte(plain_byte());
                end
            end
            4, 5, 6, 7:
            begin
                push_byte(csvft_pkg::CH_QUOTE);
                for (int i = 0; i < len; i++)
                begin
                    b = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 5) == 0)
                        b = csvft_pkg::CH_QUOTE;
                    else if ($urandom_range(0, 5) == 0)
                        b = ($urandom_range(0, 1) == 0) ? csvft_pkg::CH_COMMA : csvft_pkg::CH_NL;
                    push_byte(b);
                    if (b == csvft_pkg::CH_QUOTE)
                        push_byte(csvft_pkg::CH_QUOTE);
                end
                push_byte(csvft_pkg::CH_QUOTE);
                // Junk after the closing quote.
                if ($urandom_range(4, 7) == 7)
                begin
                    for (int i = 0; i < $urandom_range(1, 3); i++)
                        push_byte(plain_byte());
                end
            end
            8:
            begin
            end
            default:
            begin
                for (int i = 0; i <= len % 4; i++)
                    push_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    function automatic void build_stimulus();
        foreach (directed_rows[i])
            stimulus.push_back(directed_rows[i]);

        // Random records of one to five fields.
        while (stimulus.size() < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            int fields;
            fields = $urandom_range(1, 5);
            for (int f = 0; f < fields; f++)
            begin
                gen_field();
                push_byte((f == fields - 1) ? csvft_pkg::CH_NL : csvft_pkg::CH_COMMA);
            end
        end

        // Leave the lexer in a random state before end of input.
        case ($urandom_range(0, 5))
            0: ;
            1: push_byte(csvft_pkg::CH_COMMA);
            2: push_byte(plain_byte());
            3:
            begin
                push_byte(csvft_pkg::CH_QUOTE);
                push_byte(plain_byte());
            end
            4:
            begin
                push_byte(csvft_pkg::CH_QUOTE);
                push_byte(csvft_pkg::CH_QUOTE);
            end
            default:
            begin
                push_byte(csvft_pkg::CH_QUOTE);
                push_byte(csvft_pkg::CH_QUOTE);
                push_byte(plain_byte());
            end
        endcase
        stimulus.push_back(row_pred(csvft_pkg::KIND_EOI, 8'($urandom_range(0, 255))));

        // Everything after end of input must be ignored.
        for (int i = 0; i < $urandom_range(2, 5); i++)
            stimulus.push_back(row_pred(1'($urandom_range(0, 1)),
                                        8'($urandom_range(0, 255))));
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Input side: directed table, random records, bursts with gaps
    // ------------------------------------------------------------------

    initial
    begin
        int idx;
        int burst_left;
        int gap;

        in_ch.valid     <= 1'b0;
        in_ch.kind      <= csvft_pkg::KIND_BYTE;
        in_ch.data_byte <= 8'h00;

        // Directed table; the lexer starts at field start after reset.
        directed_rows = '{
            row_typed(csvft_pkg::KIND_BYTE, 8'h61, 2'd1,
                      tok(csvft_pkg::RK_VALUE, 8'h61, 2'd0, 1'b1), NO_TOK, NO_TOK),
            row_typed(csvft_pkg::KIND_BYTE, 8'h00, 2'd1,
                      tok(csvft_pkg::RK_VALUE, 8'h00, 2'd0, 1'b1), NO_TOK, NO_TOK),
            row_typed(csvft_pkg::KIND_BYTE, 8'hFF, 2'd1,
                      tok(csvft_pkg::RK_VALUE, 8'hFF, 2'd0, 1'b1), NO_TOK, NO_TOK),
            row_typed(csvft_pkg::KIND_BYTE, csvft_pkg::CH_QUOTE, 2'd1,
                      tok(csvft_pkg::RK_ERROR, 8'h00, csvft_pkg::ERR_STRAY_QUOTE, 1'b1),
                      NO_TOK, NO_TOK),
            row_typed(csvft_pkg::KIND_BYTE, csvft_pkg::CH_COMMA, 2'd1,
                      tok(csvft_pkg::RK_FIELD_END, 8'h00, 2'd0, 1'b1), NO_TOK, NO_TOK),
            // Empty field between two commas.
            row_typed(csvft_pkg::KIND_BYTE, csvft_pkg::CH_COMMA, 2'd1,
                      tok(csvft_pkg::RK_FIELD_END, 8'h00, 2'd0, 1'b1), NO_TOK, NO_TOK),
            row_typed(csvft_pkg::KIND_BYTE, csvft_pkg::CH_NL, 2'd2,
                      tok(csvft_pkg::RK_FIELD_END, 8'h00, 2'd0, 1'b0),
                      tok(csvft_pkg::RK_NEWLINE, 8'h00, 2'd0, 1'b1), NO_TOK),
            // Empty row.
            row_typed(csvft_pkg::KIND_BYTE, csvft_pkg::CH_NL, 2'd2,
                      tok(csvft_pkg::RK_FIELD_END, 8'h00, 2'd0, 1'b0),
                      tok(csvft_pkg::RK_NEWLINE, 8'h00, 2'd0, 1'b1), NO_TOK),
            row_typed(csvft_pkg::KIND_BYTE, csvft_pkg::CH_QUOTE, 2'd0, NO_TOK, NO_TOK, NO_TOK),
            // Quoted content with comma, newline, doubled quote, CR and 0xFF.
            row_pred(csvft_pkg::KIND_BYTE, csvft_pkg::CH_COMMA),
            row_pred(csvft_pkg::KIND_BYTE, csvft_pkg::CH_NL),
            row_pred(csvft_pkg::KIND_BYTE, csvft_pkg::CH_QUOTE),
            row_pred(csvft_pkg::KIND_BYTE, csvft_pkg::CH_QUOTE),
            row_pred(csvft_pkg::KIND_BYTE, 8'h0D),
            row_pred(csvft_pkg::KIND_BYTE, 8'hFF),
            row_pred(csvft_pkg::KIND_BYTE, csvft_pkg::CH_QUOTE),
            // Characters after the closing quote, a quote among them.
            row_typed(csvft_pkg::KIND_BYTE, 8'h78, 2'd1,
                      tok(csvft_pkg::RK_ERROR, 8'h00, csvft_pkg::ERR_AFTER_QUOTE, 1'b1),
                      NO_TOK, NO_TOK),
            row_typed(csvft_pkg::KIND_BYTE, 8'h80, 2'd1,
                      tok(csvft_pkg::RK_ERROR, 8'h00, csvft_pkg::ERR_AFTER_QUOTE, 1'b1),
                      NO_TOK, NO_TOK),
            row_typed(csvft_pkg::KIND_BYTE, csvft_pkg::CH_QUOTE, 2'd1,
                      tok(csvft_pkg::RK_ERROR, 8'h00, csvft_pkg::ERR_AFTER_QUOTE, 1'b1),
                      NO_TOK, NO_TOK),
            row_pred(csvft_pkg::KIND_BYTE, csvft_pkg::CH_NL),
            // Empty quoted field.
            row_pred(csvft_pkg::KIND_BYTE, csvft_pkg::CH_QUOTE),
            row_pred(csvft_pkg::KIND_BYTE, csvft_pkg::CH_QUOTE),
            row_pred(csvft_pkg::KIND_BYTE, csvft_pkg::CH_COMMA),
            // Carriage return as plain data.
            row_pred(csvft_pkg::KIND_BYTE, 8'h0D),
            row_pred(csvft_pkg::KIND_BYTE, csvft_pkg::CH_NL)
        };
        build_stimulus();

        wait (rst_n === 1'b1);
        @(posedge clk);

        idx = 0;
        burst_left = $urandom_range(1, 16);
        while (idx < stimulus.size())
        begin
            in_ch.valid     <= 1'b1;
            in_ch.kind      <= stimulus[idx].kind;
            in_ch.data_byte <= stimulus[idx].ch;
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
            idx++;
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
                gap = $urandom_range(0, 5);
                if (gap > 0)
                begin
                    in_ch.valid     <= 1'b0;
                    in_ch.data_byte <= 8'($urandom_range(0, 255));
                    repeat (gap) @(posedge clk);
                end
            end
        end
        in_ch.valid <= 1'b0;

        // Drain the expected tokens, then give stray results time to show.
        do
            @(posedge clk);
        while (pending_tokens.size() != 0);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("csv_field_tokenizer: match");
        else
            $display("csv_field_tokenizer: mismatch");
        $finish;
    end

    // Record the expected tokens of every input transfer.
    always @(posedge clk)
    begin : accept_monitor
        stim_row_t row;
        int n;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            row = stimulus[accepted_count];
            accepted_count++;
            n = tokenize_byte(row.kind, row.ch);
            if (row.typed)
            begin
                for (int i = 0; i < row.n_exp; i++)
                    pending_tokens.push_back(row.exp[i]);
            end
            else
            begin
                for (int i = 0; i < n; i++)
                    pending_tokens.push_back(predicted[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: stall patterns and checking
    // ------------------------------------------------------------------

    initial
    begin
        int stall_mode;
        int stall_left;
        logic [7:0] stall_pat;

        stall_left = 0;
        stall_mode = 0;
        stall_pat  = 8'hFF;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 80);
                stall_pat  = 8'($urandom_range(0, 255)) | 8'h01;
            end
            stall_left--;
            stall_pat = {stall_pat[6:0], stall_pat[7]};
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= stall_pat[0];
                2: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // Compare each result transfer with the oldest expected token.
    always @(posedge clk)
    begin : result_check
        token_t want;
        token_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = tok(out_ch.result_kind, out_ch.value_byte, out_ch.error_code, out_ch.last);
            if (pending_tokens.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %0d %02h %0d %0d",
                         $time, got.kind, got.value, got.err, got.last);
                mismatches++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected kind/value/err/last %0d %02h %0d %0d,",
                             $time, want.kind, want.value, want.err, want.last);
                    $display("%0t:   actual kind/value/err/last %0d %02h %0d %0d",
                             $time, got.kind, got.value, got.err, got.last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d tokens outstanding", $time, pending_tokens.size());
        $display("csv_field_tokenizer: mismatch");
        $finish;
    end

    initial
    begin
        lex_state      = csvft_pkg::S_START;
        accepted_count = 0;
        mismatches     = 0;
    end

endmodule
